@@ design/joint_command_slew_limiter_macros.svh @@
// Assertion macros for the joint command slew limiter.
`ifndef JOINT_COMMAND_SLEW_LIMITER_MACROS_SVH
`define JOINT_COMMAND_SLEW_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
`define JCSL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("joint command slew limiter: property violated");
`define JCSL_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("joint command slew limiter: forbidden condition");
`else
`define JCSL_ASSERT(label, clk, rst_n, prop)
`define JCSL_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ design/jcsl_pkg.sv @@
// Types, constants and arithmetic helpers of the joint command slew limiter.
`timescale 1ns / 1ps
package jcsl_pkg;

	localparam int JOINTS     = 4;
	localparam int POS_W      = 16;
	localparam int RATE_W     = 15;
	localparam int DT_W       = 16;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [POS_W:0]   diff_t;
	typedef logic [RATE_W-1:0]       rate_t;
	typedef logic [DT_W-1:0]         dt_t;

	// Item kinds carried in tuser.
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TARGET = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_JOG    = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MAX_RATE_A     = 3'd0,
		REG_MAX_RATE_B     = 3'd1,
		REG_MAX_RATE_C     = 3'd2,
		REG_MAX_RATE_D     = 3'd3,
		REG_SOFT_BOUND_A   = 3'd4,
		REG_SOFT_BOUND_BCD = 3'd5
	} reg_idx_t;

	localparam rate_t MAX_RATE_A_RST     = RATE_W'(3215);
	localparam rate_t MAX_RATE_BCD_RST   = RATE_W'(6435);
	localparam rate_t SOFT_BOUND_A_RST   = RATE_W'(10691);
	localparam rate_t SOFT_BOUND_BCD_RST = RATE_W'(6308);

	// Jog constants: -1.54 rad floor, -0.1 rad tilt, 0.05 rad tolerance.
	localparam pos_t  JOG_FLOOR = -POS_W'(6308);
	localparam pos_t  JOG_TILT  = -POS_W'(410);
	localparam diff_t JOG_TOL   = (POS_W+1)'(205);

	// Largest step per tick: (rate * dt) >> 16. With a 15-bit rate the result
	// stays below the largest position, so no saturation is needed.
	function automatic pos_t step_size(input rate_t rate, input dt_t dt);
		logic [RATE_W+DT_W-1:0] prod;
		prod = (RATE_W+DT_W)'(rate) * (RATE_W+DT_W)'(dt);
		return pos_t'({1'b0, prod[RATE_W+DT_W-1:DT_W]});
	endfunction

	// Move cmd toward tgt by at most step; land on the target when close.
	function automatic pos_t slew(input pos_t cmd, input pos_t tgt, input pos_t step);
		diff_t delta;
		diff_t mag;
		diff_t next;
		delta = diff_t'(tgt) - diff_t'(cmd);
		mag   = delta[POS_W] ? -delta : delta;
		if (mag > diff_t'(step)) begin
			next = delta[POS_W] ? diff_t'(cmd) - diff_t'(step)
			                    : diff_t'(cmd) + diff_t'(step);
			return next[POS_W-1:0];
		end
		return tgt;
	endfunction

	// Clamp to the symmetric range [-bound, +bound].
	function automatic pos_t clamp_sym(input pos_t v, input rate_t bound);
		pos_t b;
		b = pos_t'({1'b0, bound});
		if (v > b) begin
			return b;
		end
		if (v < -b) begin
			return -b;
		end
		return v;
	endfunction

	// True when |a - b| is within the jog tolerance.
	function automatic logic near(input pos_t a, input pos_t b);
		diff_t d;
		d = diff_t'(a) - diff_t'(b);
		if (d[POS_W]) begin
			d = -d;
		end
		return d <= JOG_TOL;
	endfunction

endpackage

@@ design/joint_command_slew_limiter.sv @@
// Four-joint position command shaper with slew limiting, soft clamp and jog.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tuser: cmd; tdata: values, flags
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: commands, jog_done, ready
//  cfg      | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled. An accepted item
// sits in the input stage, where the per-joint multiply, compare and clamp update
// the joint state and load the result register; the result passes the input stage
// register and then the result register. Reset clears joint state, the started
// flag and both stages and loads the register defaults. A stalled output holds its
// result while the input stage keeps one more item before tready drops.
`timescale 1ns / 1ps
`include "joint_command_slew_limiter_macros.svh"
module joint_command_slew_limiter
	import jcsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input items.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [15:0] joint_a_value, [31:16] joint_b_value, [47:32] joint_c_value,
	// [63:48] joint_d_value, [64] sample_valid, [80:65] step_time,
	// [81] apply_bounds, [87:82] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]            s_axis_tuser,
	// Result items.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] joint_a_cmd, [31:16] joint_b_cmd, [47:32] joint_c_cmd,
	// [63:48] joint_d_cmd, [64] jog_done, [65] ready_res, [71:66] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration writes.
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [RATE_W-1:0]     cfg_data
);

	// Input stage.
	logic  valid_s1;
	cmd_t  cmd_s1;
	pos_t  val_s1 [JOINTS];
	logic  sample_valid_s1;
	dt_t   step_time_s1;
	logic  apply_bounds_s1;

	// Result register.
	logic  out_valid_q;
	pos_t  out_cmd_q [JOINTS];
	logic  out_jog_done_q;
	logic  out_ready_q;

	// Joint state and configuration.
	pos_t  cmd_q [JOINTS];
	pos_t  tgt_q [JOINTS];
	pos_t  pos_q [JOINTS];
	logic  started_q;
	rate_t max_rate_q [JOINTS];
	rate_t soft_bound_a_q;
	rate_t soft_bound_bcd_q;

	// Next state from the item in the input stage.
	pos_t  cmd_n [JOINTS];
	pos_t  tgt_n [JOINTS];
	pos_t  pos_n [JOINTS];
	logic  started_n;
	logic  jog_done_n;
	logic  adv;

	// The input stage moves on when the result register is free or emptying.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1          <= cmd_t'(s_axis_tuser);
			for (int i = 0; i < JOINTS; i++) begin
				val_s1[i] <= pos_t'(s_axis_tdata[i*POS_W +: POS_W]);
			end
			sample_valid_s1 <= s_axis_tdata[JOINTS*POS_W];
			step_time_s1    <= s_axis_tdata[JOINTS*POS_W+1 +: DT_W];
			apply_bounds_s1 <= s_axis_tdata[JOINTS*POS_W+1+DT_W];
		end
	end

	// Per-joint update for the current item.
	always_comb begin
		logic low1;
		logic low2;
		pos_t jog_tgt [JOINTS];
		pos_t bound_cmd;
		cmd_n      = cmd_q;
		tgt_n      = tgt_q;
		pos_n      = pos_q;
		started_n  = started_q;
		jog_done_n = 1'b0;
		bound_cmd  = '0;
		low1       = pos_q[1] < JOG_FLOOR;
		low2       = pos_q[2] < JOG_FLOOR;
		jog_tgt[0] = pos_q[0];
		jog_tgt[1] = low1 ? JOG_FLOOR : pos_q[1];
		jog_tgt[2] = low2 ? JOG_FLOOR : pos_q[2];
		jog_tgt[3] = (pos_q[3] < JOG_TILT && (low1 || low2)) ? '0 : pos_q[3];
		unique case (cmd_s1)
			CMD_SAMPLE: begin
				if (sample_valid_s1) begin
					pos_n = val_s1;
					if (!started_q) begin
						cmd_n     = val_s1;
						tgt_n     = val_s1;
						started_n = 1'b1;
					end
				end
			end
			CMD_TARGET: begin
				tgt_n = val_s1;
			end
			CMD_TICK: begin
				for (int i = 0; i < JOINTS; i++) begin
					bound_cmd = cmd_q[i];
					if (step_time_s1 != '0) begin
						bound_cmd = started_q
						            ? slew(cmd_q[i], tgt_q[i],
						                   step_size(max_rate_q[i], step_time_s1))
						            : tgt_q[i];
					end
					if (apply_bounds_s1) begin
						bound_cmd = clamp_sym(bound_cmd,
						                      (i == 0) ? soft_bound_a_q : soft_bound_bcd_q);
					end
					cmd_n[i] = bound_cmd;
				end
			end
			CMD_JOG: begin
				jog_done_n = 1'b1;
				for (int i = 0; i < JOINTS; i++) begin
					tgt_n[i] = jog_tgt[i];
					cmd_n[i] = jog_tgt[i];
					if (!near(jog_tgt[i], pos_q[i])) begin
						jog_done_n = 1'b0;
					end
				end
			end
			default: begin
				cmd_n = cmd_q;
			end
		endcase
	end

	// Joint state commits when the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				cmd_q[i] <= '0;
				tgt_q[i] <= '0;
				pos_q[i] <= '0;
			end
			started_q <= 1'b0;
		end else if (adv) begin
			cmd_q     <= cmd_n;
			tgt_q     <= tgt_n;
			pos_q     <= pos_n;
			started_q <= started_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cmd_q      <= cmd_n;
			out_jog_done_q <= jog_done_n;
			out_ready_q    <= started_n;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < JOINTS; i++) begin
			m_axis_tdata[i*POS_W +: POS_W] = out_cmd_q[i];
		end
		m_axis_tdata[JOINTS*POS_W]   = out_jog_done_q;
		m_axis_tdata[JOINTS*POS_W+1] = out_ready_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q[0]    <= MAX_RATE_A_RST;
			max_rate_q[1]    <= MAX_RATE_BCD_RST;
			max_rate_q[2]    <= MAX_RATE_BCD_RST;
			max_rate_q[3]    <= MAX_RATE_BCD_RST;
			soft_bound_a_q   <= SOFT_BOUND_A_RST;
			soft_bound_bcd_q <= SOFT_BOUND_BCD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_RATE_A:     max_rate_q[0]    <= cfg_data;
				REG_MAX_RATE_B:     max_rate_q[1]    <= cfg_data;
				REG_MAX_RATE_C:     max_rate_q[2]    <= cfg_data;
				REG_MAX_RATE_D:     max_rate_q[3]    <= cfg_data;
				REG_SOFT_BOUND_A:   soft_bound_a_q   <= cfg_data;
				REG_SOFT_BOUND_BCD: soft_bound_bcd_q <= cfg_data;
				default:            soft_bound_bcd_q <= soft_bound_bcd_q;
			endcase
		end
	end

	// Once initialized, the block stays initialized until reset.
	`JCSL_ASSERT_NEVER(a_started_sticky, clk, arst_n, $fell(started_q))
	// A result that reports ready agrees with the live started flag.
	`JCSL_ASSERT(a_ready_matches, clk, arst_n, (out_valid_q && out_ready_q) |-> started_q)
	// Only a jog can produce a jog_done result.
	`JCSL_ASSERT(a_jog_done_only_jog, clk, arst_n, (adv && cmd_s1 != CMD_JOG) |=> !out_jog_done_q)

endmodule
